>>> rtl/hes_pkg.sv
// Shared constants and helper functions for the Hamming encode / syndrome core.
// No dependencies.
package hes_pkg;

  localparam int DATA_W     = 57;
  localparam int CODE_W     = 63;
  localparam int LEN_W      = 6;
  localparam int PAR_W      = 3;
  localparam int SYN_W      = 6;
  localparam int MAX_DATA_BITS_DFLT = 57;
  localparam logic [LEN_W-1:0] DATA_LEN_RST = LEN_W'(7);

  localparam logic REQ_ENCODE = 1'b0;
  localparam logic REQ_CHECK  = 1'b1;

  // true when position pos (1-based) is a power of two
  function automatic logic is_pow2(input int pos);
    return (pos & (pos - 1)) == 0;
  endfunction

  // data bit index carried at a non-power-of-two position
  function automatic logic [LEN_W-1:0] data_idx(input int pos);
    int lg;
    lg = 0;
    for (int b = 0; b < SYN_W; b++) begin
      if (((pos >> b) & 1) != 0) lg = b;
    end
    return LEN_W'(pos - lg - 2);
  endfunction

  // codeword positions whose index has bit j set
  function automatic logic [CODE_W-1:0] pos_mask(input int j);
    logic [CODE_W-1:0] msk;
    msk = '0;
    for (int p = 0; p < CODE_W; p++) begin
      msk[p] = (((p + 1) >> j) & 1) != 0;
    end
    return msk;
  endfunction

  // smallest r with 2^r >= m + r + 1, for m in 1..57
  function automatic logic [PAR_W-1:0] parity_bits(input logic [LEN_W-1:0] m);
    logic [PAR_W-1:0] r;
    if (m <= LEN_W'(1))       r = PAR_W'(2);
    else if (m <= LEN_W'(4))  r = PAR_W'(3);
    else if (m <= LEN_W'(11)) r = PAR_W'(4);
    else if (m <= LEN_W'(26)) r = PAR_W'(5);
    else                      r = PAR_W'(6);
    return r;
  endfunction

endpackage

>>> rtl/hes_req_if.sv
// Request channel: valid/ready handshake with encode or check payload.
// Depends on hes_pkg.
interface hes_req_if import hes_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [DATA_W-1:0] data_word;
  logic [CODE_W-1:0] codeword_in;

  modport source (output valid, req_type, data_word, codeword_in, input ready);
  modport sink   (input valid, req_type, data_word, codeword_in, output ready);
endinterface

>>> rtl/hes_res_if.sv
// Result channel: valid/ready handshake with codeword, parity count and syndrome.
// Depends on hes_pkg.
interface hes_res_if import hes_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] codeword_out;
  logic [PAR_W-1:0]  parity_count;
  logic [SYN_W-1:0]  syndrome;
  logic              error_found;

  modport source (output valid, codeword_out, parity_count, syndrome, error_found,
                  input ready);
  modport sink   (input valid, codeword_out, parity_count, syndrome, error_found,
                  output ready);
endinterface

>>> rtl/hamming_encode_and_syndrome_core.sv
// Hamming encoder and syndrome checker, configurable data length.
// Depends on hes_pkg, hes_req_if, hes_res_if.
// Result path: an accepted request is captured in the input reg, then moves to the result reg.
// Throughput: one request per cycle while the result channel is not stalled; XOR trees between the two registers.
// Reset (rst, synchronous): clears both valid stages, data_len returns to 7.
module hamming_encode_and_syndrome_core import hes_pkg::*; #(
  parameter int MAX_DATA_BITS = MAX_DATA_BITS_DFLT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata,
  hes_req_if.sink          req,
  hes_res_if.source        res
);

  logic [LEN_W-1:0]  data_len;
  logic              s1_valid;
  logic              s1_req_type;
  logic [DATA_W-1:0] s1_data;
  logic [CODE_W-1:0] s1_code;
  logic              out_valid;
  logic [CODE_W-1:0] out_code;
  logic [PAR_W-1:0]  out_par;
  logic [SYN_W-1:0]  out_syn;
  logic              out_err;

  logic              adv;
  logic [LEN_W-1:0]  m;
  logic [PAR_W-1:0]  r;
  logic [LEN_W-1:0]  n;
  logic [CODE_W-1:0] len_mask;
  logic [CODE_W-1:0] cw_data;
  logic [CODE_W-1:0] cw_enc;
  logic [CODE_W-1:0] cw_chk;
  logic [SYN_W-1:0]  syn;
  logic [SYN_W-1:0]  par;

  assign adv       = !out_valid || res.ready;
  assign req.ready = !s1_valid || adv;

  always_comb begin
    m = data_len;
    if (m == '0) m = LEN_W'(1);
    if (m > LEN_W'(MAX_DATA_BITS)) m = LEN_W'(MAX_DATA_BITS);
    r = parity_bits(m);
    n = m + LEN_W'(r);
  end

  always_comb begin
    for (int p = 0; p < CODE_W; p++) begin
      len_mask[p] = LEN_W'(p) < n;
      if (is_pow2(p + 1)) begin
        cw_data[p] = 1'b0;
      end else begin
        cw_data[p] = s1_data[data_idx(p + 1)] && (data_idx(p + 1) < m);
      end
    end
    cw_chk = s1_code & len_mask;
    for (int j = 0; j < SYN_W; j++) begin
      par[j] = ^(cw_data & pos_mask(j));
      syn[j] = ^(cw_chk & pos_mask(j));
    end
    cw_enc = cw_data;
    for (int j = 0; j < SYN_W; j++) begin
      cw_enc[(1 << j) - 1] = par[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data_len  <= DATA_LEN_RST;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) data_len <= cfg_wdata;
      if (req.ready) s1_valid <= req.valid;
      if (adv) out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      s1_req_type <= req.req_type;
      s1_data     <= req.data_word;
      s1_code     <= req.codeword_in;
    end
    if (adv && s1_valid) begin
      out_par <= r;
      if (s1_req_type == REQ_ENCODE) begin
        out_code <= cw_enc;
        out_syn  <= '0;
        out_err  <= 1'b0;
      end else begin
        out_code <= '0;
        out_syn  <= syn;
        out_err  <= syn != '0;
      end
    end
  end

  assign res.valid        = out_valid;
  assign res.codeword_out = out_code;
  assign res.parity_count = out_par;
  assign res.syndrome     = out_syn;
  assign res.error_found  = out_err;

endmodule

>>> tb/sv/tb.sv
// Self-checking bench for hamming_encode_and_syndrome_core: encode and check requests
// over several data lengths, checked against an in-bench parity/syndrome predictor.
// Depends on hes_pkg, hes_req_if, hes_res_if and the core.
module tb import hes_pkg::*; ();

  typedef struct packed {
    logic              kind;
    logic [DATA_W-1:0] data;
    logic [CODE_W-1:0] code;
  } hes_request_t;

  typedef struct packed {
    logic [CODE_W-1:0] cw;
    logic [PAR_W-1:0]  par;
    logic [SYN_W-1:0]  syn;
    logic              err;
  } hes_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we;
  logic [LEN_W-1:0] cfg_wdata;

  hes_req_if req_ch ();
  hes_res_if res_ch ();

  hamming_encode_and_syndrome_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .res       (res_ch)
  );

  hes_request_t     pending_reqs[$];
  hes_result_t      expected_results[$];
  hes_request_t     cur_req;
  hes_result_t      got_res;
  hes_result_t      want_res;
  logic [LEN_W-1:0] len_cfg = DATA_LEN_RST;
  int               idle_mode = 0;
  int               fail_count = 0;
  logic             hold_arm = 1'b0;
  int               hold_left = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    req_ch.valid       = 1'b0;
    req_ch.req_type    = REQ_ENCODE;
    req_ch.data_word   = '0;
    req_ch.codeword_in = '0;
    res_ch.ready       = 1'b0;
  end

  function automatic int eff_data_len(logic [LEN_W-1:0] v);
    int m;
    m = v;
    if (m < 1) m = 1;
    if (m > MAX_DATA_BITS_DFLT) m = MAX_DATA_BITS_DFLT;
    return m;
  endfunction

  function automatic hes_result_t hamming_predict(hes_request_t rq, logic [LEN_W-1:0] len_v);
    int m;
    int r;
    int n;
    int k;
    logic [SYN_W-1:0] acc;
    hes_result_t o;
    m = eff_data_len(len_v);
    r = 0;
    while ((1 << r) < m + r + 1) r++;
    n = m + r;
    o = '0;
    o.par = PAR_W'(r);
    acc = '0;
    k = 0;
    if (rq.kind == REQ_ENCODE) begin
      for (int i = 1; i <= n; i++) begin
        if ((i & (i - 1)) != 0) begin
          if (rq.data[k]) begin
            o.cw[i-1] = 1'b1;
            acc ^= SYN_W'(i);
          end
          k++;
        end
      end
      for (int j = 0; j < r; j++) begin
        if (acc[j]) o.cw[(1 << j) - 1] = 1'b1;
      end
    end else begin
      for (int i = 1; i <= n; i++) begin
        if (rq.code[i-1]) acc ^= SYN_W'(i);
      end
      o.syn = acc;
      o.err = (acc != '0);
    end
    return o;
  endfunction

  function automatic logic [CODE_W-1:0] rand_code();
    return CODE_W'({$urandom(), $urandom()});
  endfunction

  function automatic logic [DATA_W-1:0] rand_data();
    return DATA_W'({$urandom(), $urandom()});
  endfunction

  function automatic logic sender_idles();
    if (idle_mode == 1) return $urandom_range(99) < 83;
    if (idle_mode == 3) return $urandom_range(99) < 6;
    return 1'b0;
  endfunction

  function automatic logic receiver_stalls();
    if (idle_mode == 2) return $urandom_range(99) < 83;
    if (idle_mode == 3) return $urandom_range(99) < 6;
    return 1'b0;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready)
        expected_results = {expected_results, hamming_predict(cur_req, len_cfg)};
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_reqs.size() != 0 && !sender_idles()) begin
          cur_req = pending_reqs.pop_front();
          req_ch.valid       <= 1'b1;
          req_ch.req_type    <= cur_req.kind;
          req_ch.data_word   <= cur_req.data;
          req_ch.codeword_in <= cur_req.code;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (rst) hold_left <= 0;
    else if (hold_arm) hold_left <= 300;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got_res = '{res_ch.codeword_out, res_ch.parity_count, res_ch.syndrome,
                    res_ch.error_found};
        if (expected_results.size() == 0) begin
          $error("unexpected result: codeword_out %h syndrome %0d", got_res.cw, got_res.syn);
          fail_count++;
        end else begin
          want_res = expected_results.pop_front();
          if (got_res.cw !== want_res.cw) begin
            $error("codeword_out expected %h actual %h", want_res.cw, got_res.cw);
            fail_count++;
          end
          if (got_res.par !== want_res.par) begin
            $error("parity_count expected %0d actual %0d", want_res.par, got_res.par);
            fail_count++;
          end
          if (got_res.syn !== want_res.syn) begin
            $error("syndrome expected %0d actual %0d", want_res.syn, got_res.syn);
            fail_count++;
          end
          if (got_res.err !== want_res.err) begin
            $error("error_found expected %0d actual %0d", want_res.err, got_res.err);
            fail_count++;
          end
        end
      end
      res_ch.ready <= (hold_left == 0) && !receiver_stalls();
    end
  end

  task automatic add_req(logic kind, logic [DATA_W-1:0] d, logic [CODE_W-1:0] c);
    hes_request_t rq;
    rq.kind = kind;
    rq.data = d;
    rq.code = c;
    pending_reqs = {pending_reqs, rq};
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || req_ch.valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_data_len(logic [LEN_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    len_cfg = v;
    @(negedge clk);
  endtask

  function automatic logic [CODE_W-1:0] encode_of(logic [DATA_W-1:0] d);
    hes_request_t rq;
    hes_result_t  o;
    rq = '{REQ_ENCODE, d, '0};
    o = hamming_predict(rq, len_cfg);
    return o.cw;
  endfunction

  task automatic add_random_req();
    int sel;
    int n;
    logic [CODE_W-1:0] cw;
    logic [CODE_W-1:0] low_mask;
    logic [DATA_W-1:0] d;
    hes_result_t pr;
    sel = $urandom_range(9);
    pr = hamming_predict('0, len_cfg);
    n = eff_data_len(len_cfg) + int'(pr.par);
    low_mask = CODE_W'((64'd1 << n) - 64'd1);
    d = rand_data();
    if ($urandom_range(3) == 0) d = d & rand_data() & rand_data();
    if (sel < 4) begin
      add_req(REQ_ENCODE, d, rand_code());
    end else if (sel < 8) begin
      // good codeword, zero to two flipped positions, sometimes junk above length
      cw = encode_of(d);
      repeat ($urandom_range(2)) cw[$urandom_range(n, 1) - 1] ^= 1'b1;
      if ($urandom_range(3) == 0) cw |= rand_code() & ~low_mask;
      add_req(REQ_CHECK, rand_data(), cw);
    end else begin
      add_req(REQ_CHECK, rand_data(), rand_code());
    end
  endtask

  initial begin
    logic [CODE_W-1:0] cw;
    int len_plan[14];
    len_plan = '{0, 57, 1, 63, 2, 58, 4, 5, 11, 12, 26, 27, 42, 21};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed, reset data length of 7
    add_req(REQ_ENCODE, '0, '0);
    add_req(REQ_ENCODE, '1, '1);
    for (int b = 0; b < 7; b++) add_req(REQ_ENCODE, DATA_W'(1) << b, '0);
    add_req(REQ_ENCODE, {50'h2_aaaa_aaaa_aaaa, 7'h55}, '0);
    add_req(REQ_CHECK, '1, '0);
    add_req(REQ_CHECK, '0, '1);
    cw = encode_of(DATA_W'(7'h5a));
    add_req(REQ_CHECK, '0, cw);
    add_req(REQ_CHECK, '0, cw ^ CODE_W'(1));
    add_req(REQ_CHECK, '0, cw ^ CODE_W'(2));
    add_req(REQ_CHECK, '0, cw ^ CODE_W'(8));
    add_req(REQ_CHECK, '0, cw ^ CODE_W'(128));
    add_req(REQ_CHECK, '0, cw ^ CODE_W'(1024));
    add_req(REQ_CHECK, '0, CODE_W'(11'h408));   // syndrome 15, past the length
    add_req(REQ_CHECK, '0, cw | {52'hf_ffff_ffff_ffff, 11'h0});
    drain();

    for (int p = 0; p < 14; p++) begin
      write_data_len(LEN_W'(len_plan[p]));
      idle_mode = p % 4;
      if (p == 4) begin
        @(posedge clk);
        hold_arm <= 1'b1;
        @(posedge clk);
        hold_arm <= 1'b0;
      end
      for (int j = 0; j < 35; j++) begin
        if (p == 6 && j == 17) drain();
        add_random_req();
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #400000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
